// ----- design/sdsc_pkg.sv -----
package sdsc_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_POLL = 2'd1,
    PH_PAIR = 2'd2
  } phase_t;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_BYTE  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_CARD      = 3'd1,
    ERR_IDLE      = 3'd2,
    ERR_ERASE     = 3'd3,
    ERR_ILLEGAL   = 3'd4,
    ERR_CRC       = 3'd5,
    ERR_ADDRESS   = 3'd6,
    ERR_PARAMETER = 3'd7
  } err_t;

  // one classified request handed from the front to the back
  typedef struct packed {
    logic        is_frame;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
    logic [7:0]  status;
  } entry_t;

  localparam logic [7:0] FRAME_START    = 8'h40;
  localparam logic [7:0] CRC_CMD0       = 8'h95;
  localparam logic [7:0] CRC_CMD8       = 8'h87;
  localparam logic [7:0] CRC_OTHER      = 8'h01;
  localparam logic [7:0] BYTE_IDLE      = 8'hFF;
  localparam logic [7:0] BYTE_BUSY      = 8'h7F;
  localparam logic [7:0] FAIL_MASK      = 8'h7E;
  localparam logic [7:0] POLLS_RESET    = 8'd10;
  localparam logic [5:0] IDX_CMD0       = 6'd0;
  localparam logic [5:0] IDX_CMD8       = 6'd8;
  localparam logic [2:0] FRAME_LAST_IDX = 3'd5;

  // drop the leading one bits of a joined byte pair, keep the upper byte
  function automatic logic [7:0] realign(input logic [15:0] w);
    logic [4:0]  n;
    logic [15:0] s;
    n = 5'd16;
    for (int i = 0; i < 16; i++) begin
      if (!w[i]) begin
        n = 5'(15 - i);
      end
    end
    s = w << n;
    return s[15:8];
  endfunction

  function automatic err_t code_of(input logic [7:0] s);
    err_t c;
    if (s == 8'h00)           c = ERR_OK;
    else if (s == BYTE_IDLE)  c = ERR_CARD;
    else if (s[0])            c = ERR_IDLE;
    else if (s[1])            c = ERR_ERASE;
    else if (s[2])            c = ERR_ILLEGAL;
    else if (s[3])            c = ERR_CRC;
    else if (s[4])            c = ERR_ERASE;
    else if (s[5])            c = ERR_ADDRESS;
    else if (s[6])            c = ERR_PARAMETER;
    else                      c = ERR_CARD;
    return c;
  endfunction

endpackage

// ----- design/sdsc_front.sv -----
module sdsc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                cmd,
  input  logic [5:0]          cmd_index,
  input  logic [31:0]         argument,
  input  logic [7:0]          rx_byte,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [7:0]          cfg_data,
  input  logic                queue_full,
  output logic                push,
  output sdsc_pkg::entry_t    push_entry
);

  sdsc_pkg::phase_t phase, phase_next;
  logic [7:0] polls_left, polls_left_next;
  logic [7:0] held_byte, held_byte_next;
  logic [7:0] max_polls;
  logic       accept;
  logic [7:0] poll_status;
  logic       poll_used;
  logic [7:0] dec;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;
  assign dec      = polls_left - 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_polls <= sdsc_pkg::POLLS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_polls <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= sdsc_pkg::PH_IDLE;
      polls_left <= 8'd0;
    end else begin
      phase      <= phase_next;
      polls_left <= polls_left_next;
    end
  end

  always_ff @(posedge clk) begin
    held_byte <= held_byte_next;
  end

  always_comb begin
    phase_next      = phase;
    polls_left_next = polls_left;
    held_byte_next  = held_byte;
    push            = 1'b0;
    poll_used       = 1'b0;
    poll_status     = rx_byte;
    push_entry      = '0;
    push_entry.cmd_index = cmd_index;
    push_entry.argument  = argument;

    if (accept) begin
      if (cmd == sdsc_pkg::CMD_START) begin
        push                = 1'b1;
        push_entry.is_frame = 1'b1;
        phase_next          = sdsc_pkg::PH_POLL;
        polls_left_next     = (max_polls == 8'd0) ? 8'd1 : max_polls;
      end else begin
        case (phase)
          sdsc_pkg::PH_POLL: begin
            if (rx_byte != sdsc_pkg::BYTE_IDLE && rx_byte[7]) begin
              held_byte_next = rx_byte;
              phase_next     = sdsc_pkg::PH_PAIR;
            end else begin
              poll_used   = 1'b1;
              poll_status = rx_byte;
            end
          end
          sdsc_pkg::PH_PAIR: begin
            poll_used   = 1'b1;
            poll_status = sdsc_pkg::realign({held_byte, rx_byte});
          end
          default: begin
            phase_next = sdsc_pkg::PH_IDLE;
          end
        endcase
      end
    end

    // one poll spent: finish on a real status or when the count runs out
    if (poll_used) begin
      push_entry.status = poll_status;
      if (poll_status != sdsc_pkg::BYTE_IDLE && poll_status != sdsc_pkg::BYTE_BUSY) begin
        push       = 1'b1;
        phase_next = sdsc_pkg::PH_IDLE;
      end else begin
        polls_left_next = dec;
        if (dec == 8'd0) begin
          push       = 1'b1;
          phase_next = sdsc_pkg::PH_IDLE;
        end else begin
          phase_next = sdsc_pkg::PH_POLL;
        end
      end
    end
  end

endmodule

// ----- design/sdsc_queue.sv -----
module sdsc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sdsc_pkg::entry_t push_entry,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output sdsc_pkg::entry_t head
);

  sdsc_pkg::entry_t slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/sdsc_back.sv -----
module sdsc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             queue_empty,
  input  sdsc_pkg::entry_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             is_frame,
  output logic [7:0]       tx_byte,
  output logic             frame_last,
  output logic [7:0]       status,
  output logic             failed,
  output logic [2:0]       error_code
);

  sdsc_pkg::entry_t cur;
  logic       cur_valid;
  logic [2:0] cnt;
  logic       load, last;
  logic [7:0] frame_byte, crc;

  assign crc = (cur.cmd_index == sdsc_pkg::IDX_CMD0) ? sdsc_pkg::CRC_CMD0 :
               (cur.cmd_index == sdsc_pkg::IDX_CMD8) ? sdsc_pkg::CRC_CMD8 :
               sdsc_pkg::CRC_OTHER;

  always_comb begin
    case (cnt)
      3'd0:    frame_byte = sdsc_pkg::FRAME_START | {2'b00, cur.cmd_index};
      3'd1:    frame_byte = cur.argument[31:24];
      3'd2:    frame_byte = cur.argument[23:16];
      3'd3:    frame_byte = cur.argument[15:8];
      3'd4:    frame_byte = cur.argument[7:0];
      default: frame_byte = crc;
    endcase
  end

  assign last = !cur.is_frame || (cnt == sdsc_pkg::FRAME_LAST_IDX);
  assign load = cur_valid && (!out_valid || !out_stall);
  assign pop  = !queue_empty && (!cur_valid || (load && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cnt       <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        cur_valid <= 1'b1;
        cnt       <= 3'd0;
      end else if (load && last) begin
        cur_valid <= 1'b0;
      end else if (load) begin
        cnt <= cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (load) begin
      is_frame   <= cur.is_frame;
      tx_byte    <= cur.is_frame ? frame_byte : 8'd0;
      frame_last <= cur.is_frame && (cnt == sdsc_pkg::FRAME_LAST_IDX);
      status     <= cur.is_frame ? 8'd0 : cur.status;
      failed     <= !cur.is_frame && ((cur.status & sdsc_pkg::FAIL_MASK) != 8'd0);
      error_code <= cur.is_frame ? sdsc_pkg::ERR_OK : sdsc_pkg::code_of(cur.status);
    end
  end

endmodule

// ----- design/sd_spi_command_response.sv -----
// SD card SPI-mode command exchange, host side. A start request (cmd = 0)
// yields six frame results: 0x40 | cmd_index, the argument MSB first, and
// the fixed CRC byte. Received bytes (cmd = 1) are polled for the R1 status,
// which comes out as one status result with failed and error_code. Input is
// taken one request per cycle while the two-entry queue between the input
// classifier and the output sequencer has room. The output sequencer sends
// one result per cycle while out_stall is low: a start holds it for its six
// frame results, a status for one. cfg_ready is always high; write
// max_polls only while no exchange is in flight.
module sd_spi_command_response (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [5:0]  cmd_index,
  input  logic [31:0] argument,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_frame,
  output logic [7:0]  tx_byte,
  output logic        frame_last,
  output logic [7:0]  status,
  output logic        failed,
  output logic [2:0]  error_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  sdsc_pkg::entry_t push_entry, head;
  logic push, pop, queue_full, queue_empty;

  assign cfg_ready = 1'b1;

  sdsc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .cmd_index  (cmd_index),
    .argument   (argument),
    .rx_byte    (rx_byte),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  sdsc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (queue_full),
    .empty      (queue_empty),
    .head       (head)
  );

  sdsc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .is_frame    (is_frame),
    .tx_byte     (tx_byte),
    .frame_last  (frame_last),
    .status      (status),
    .failed      (failed),
    .error_code  (error_code)
  );

endmodule

// ----- design/sdsc_chk.sv -----
module sdsc_chk (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       is_frame,
  input logic [7:0] tx_byte,
  input logic       frame_last,
  input logic [7:0] status,
  input logic       failed,
  input logic [2:0] error_code
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tx_byte) && $stable(status))
    else $error("stalled result changed");

  a_failed: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_frame |-> failed == ((status & sdsc_pkg::FAIL_MASK) != 8'h00))
    else $error("failed flag does not match status");

  a_ok_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_frame |-> (error_code == sdsc_pkg::ERR_OK) == (status == 8'h00))
    else $error("error code zero does not match status zero");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_frame |-> tx_byte == 8'h00 && !frame_last)
    else $error("status result carries frame fields");

  a_frame_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_frame |-> status == 8'h00 && !failed && error_code == sdsc_pkg::ERR_OK)
    else $error("frame result carries status fields");

endmodule

bind sd_spi_command_response sdsc_chk u_chk (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .is_frame   (is_frame),
  .tx_byte    (tx_byte),
  .frame_last (frame_last),
  .status     (status),
  .failed     (failed),
  .error_code (error_code)
);
